// ===== hdl/tsr_pkg.sv =====
package tsr_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROW_BITS      = 15;
  localparam int COLOR_BITS    = 32;
  localparam int STEP_BITS     = 32;

  localparam logic [ROW_BITS-1:0] SCREEN_WIDTH_RESET = 15'd320;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] top_x;
    logic signed [COORD_BITS-1:0] top_y;
    logic signed [COORD_BITS-1:0] top_width;
    logic signed [COORD_BITS-1:0] bottom_x;
    logic signed [COORD_BITS-1:0] bottom_y;
    logic signed [COORD_BITS-1:0] bottom_width;
    logic [COLOR_BITS-1:0]        fill_color;
    logic [ROW_BITS-1:0]          row_limit;
  } in_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   span_row;
    logic [ROW_BITS-1:0]   span_left;
    logic [ROW_BITS-1:0]   span_right;
    logic [COLOR_BITS-1:0] span_color;
    logic                  visible;
    logic                  last_row;
    logic                  no_work;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic div_run;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_step;
    logic div_needed;
    logic div_last;
  } dp_sts_t;

endpackage

// ===== hdl/tsr_div.sv =====
module tsr_div #(
  parameter int NUM_BITS = 33,
  parameter int DEN_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           run,
  input  logic [NUM_BITS-1:0]            num_a,
  input  logic [NUM_BITS-1:0]            num_b,
  input  logic [DEN_BITS-1:0]            den,
  output logic [tsr_pkg::STEP_BITS-1:0]  step_a,
  output logic [tsr_pkg::STEP_BITS-1:0]  step_b,
  output logic                           last
);

  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0]           quo_a_r, quo_b_r, quo_a_nxt, quo_b_nxt;
  logic [DEN_BITS-1:0]           rem_a_r, rem_b_r, den_r;
  logic [DEN_BITS:0]             stage_a, stage_b;
  logic [CNT_BITS-1:0]           cnt_r;
  logic [tsr_pkg::STEP_BITS-1:0] step_a_r, step_b_r;

  // One restoring division step: the top bit is the quotient bit.
  function automatic logic [DEN_BITS:0] div_stage(input logic [DEN_BITS-1:0] rem,
                                                  input logic msb,
                                                  input logic [DEN_BITS-1:0] d);
    logic [DEN_BITS:0] t;
    logic [DEN_BITS:0] diff;
    t    = {rem, msb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[DEN_BITS-1:0]};
    end else begin
      return {1'b0, t[DEN_BITS-1:0]};
    end
  endfunction

  function automatic logic [tsr_pkg::STEP_BITS-1:0] saturate(input logic [NUM_BITS-1:0] q);
    logic [63:0] w;
    w = 64'(q);
    return (|w[63:32]) ? '1 : w[31:0];
  endfunction

  assign stage_a   = div_stage(rem_a_r, quo_a_r[NUM_BITS-1], den_r);
  assign stage_b   = div_stage(rem_b_r, quo_b_r[NUM_BITS-1], den_r);
  assign quo_a_nxt = {quo_a_r[NUM_BITS-2:0], stage_a[DEN_BITS]};
  assign quo_b_nxt = {quo_b_r[NUM_BITS-2:0], stage_b[DEN_BITS]};
  assign last      = (cnt_r == CNT_BITS'(NUM_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (run) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_a_r <= num_a;
      quo_b_r <= num_b;
      rem_a_r <= '0;
      rem_b_r <= '0;
      den_r   <= den;
    end else if (run) begin
      quo_a_r <= quo_a_nxt;
      quo_b_r <= quo_b_nxt;
      rem_a_r <= stage_a[DEN_BITS-1:0];
      rem_b_r <= stage_b[DEN_BITS-1:0];
      if (last) begin
        step_a_r <= saturate(quo_a_nxt);
        step_b_r <= saturate(quo_b_nxt);
      end
    end
  end

  assign step_a = step_a_r;
  assign step_b = step_b_r;

endmodule

// ===== hdl/tsr_datapath.sv =====
module tsr_datapath #(
  parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tsr_pkg::dp_cmd_t                cmd,
  output tsr_pkg::dp_sts_t                sts,
  input  tsr_pkg::in_item_t               in_data,
  input  logic                            cfg_we,
  input  logic [tsr_pkg::ROW_BITS-1:0]    cfg_data,
  output tsr_pkg::out_item_t              out_data
);

  localparam int C        = tsr_pkg::COORD_BITS;
  localparam int RB       = tsr_pkg::ROW_BITS;
  localparam int XW       = C + 2;
  localparam int CMPW     = (C + 3 > RB + 1) ? C + 3 : RB + 1;
  localparam int NUM_BITS = C + 1 + FRAC_BITS;
  localparam int SB       = tsr_pkg::STEP_BITS;

  logic [RB-1:0]  screen_width_r;
  logic           active_r, active_nxt;

  logic [RB-1:0]  cur_row_r, end_row_r, row_inc;
  logic [XW-1:0]  cur_x_r, cur_w_r, cur_x_nxt, cur_w_nxt;
  logic [FRAC_BITS-1:0] acc_x_r, acc_w_r;
  logic           x_right_r, w_shrink_r, stop_right_r, stop_left_r;
  logic [tsr_pkg::COLOR_BITS-1:0] color_r;
  tsr_pkg::out_item_t out_r, out_nxt;

  logic signed [CMPW-1:0] ld_x1, ld_y1, ld_w1, ld_x2, ld_y2, ld_w2, scr, lim;
  logic signed [CMPW-1:0] dx, adx_full, dw, adw_full, dy_full;
  logic [C:0]     adx, adw, dy;
  logic [RB-1:0]  start_row, stop_row;
  logic           reject, ld_ok;

  logic [SB-1:0]  x_step, w_step;
  logic [SB:0]    sum_x, sum_w, int_x, int_w;
  logic           div_last;

  logic signed [CMPW-1:0] px, pw, right, left, clip_r;
  logic           leave, vis, done;

  function automatic logic signed [CMPW-1:0] sx_c(input logic [C-1:0] v);
    return signed'({{(CMPW-C){v[C-1]}}, v});
  endfunction

  function automatic logic signed [CMPW-1:0] sx_x(input logic [XW-1:0] v);
    return signed'({{(CMPW-XW){v[XW-1]}}, v});
  endfunction

  // Trapezoid load checks and setup.
  always_comb begin
    ld_x1 = sx_c(in_data.top_x);
    ld_y1 = sx_c(in_data.top_y);
    ld_w1 = sx_c(in_data.top_width);
    ld_x2 = sx_c(in_data.bottom_x);
    ld_y2 = sx_c(in_data.bottom_y);
    ld_w2 = sx_c(in_data.bottom_width);
    scr   = signed'(CMPW'(screen_width_r));
    lim   = signed'(CMPW'(in_data.row_limit));

    reject = (ld_y1 > ld_y2) ||
             ((ld_x2 + ld_w2 < 0) && (ld_x1 + ld_w1 < 0)) ||
             ((ld_x1 > scr) && (ld_x2 > scr)) ||
             (ld_y2 < 0) || (ld_y1 > lim);

    start_row = ld_y1[CMPW-1] ? '0 : ld_y1[RB-1:0];
    stop_row  = (ld_y2 > lim) ? in_data.row_limit : ld_y2[RB-1:0];
    ld_ok     = !reject && (start_row != stop_row);

    dx       = ld_x2 - ld_x1;
    adx_full = dx[CMPW-1] ? -dx : dx;
    adx      = adx_full[C:0];
    dw       = ld_w2 - ld_w1;
    adw_full = dw[CMPW-1] ? -dw : dw;
    adw      = adw_full[C:0];
    dy_full  = ld_y2 - ld_y1;
    dy       = dy_full[C:0];
  end

  tsr_div #(
    .NUM_BITS(NUM_BITS),
    .DEN_BITS(C + 1)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.load && ld_ok),
    .run    (cmd.div_run),
    .num_a  ({adx, {FRAC_BITS{1'b0}}}),
    .num_b  ({adw, {FRAC_BITS{1'b0}}}),
    .den    (dy),
    .step_a (x_step),
    .step_b (w_step),
    .last   (div_last)
  );

  assign sts = '{is_step: in_data.op, div_needed: ld_ok, div_last: div_last};

  // Row advance: only the integer part of each running fraction moves the edge.
  always_comb begin
    sum_x     = {1'b0, x_step} + (SB + 1)'(acc_x_r);
    sum_w     = {1'b0, w_step} + (SB + 1)'(acc_w_r);
    int_x     = sum_x >> FRAC_BITS;
    int_w     = sum_w >> FRAC_BITS;
    cur_x_nxt = x_right_r  ? cur_x_r + int_x[XW-1:0] : cur_x_r - int_x[XW-1:0];
    cur_w_nxt = w_shrink_r ? cur_w_r - int_w[XW-1:0] : cur_w_r + int_w[XW-1:0];
  end

  // Span clipping and result assembly.
  always_comb begin
    px      = sx_x(cur_x_r);
    pw      = sx_x(cur_w_r);
    right   = px + pw;
    leave   = (stop_right_r && (px > scr)) || (stop_left_r && (right < 0));
    left    = px[CMPW-1] ? '0 : px;
    clip_r  = (right > scr) ? scr : right;
    vis     = !clip_r[CMPW-1] && (left <= scr);
    row_inc = cur_row_r + 1'b1;
    done    = leave || (row_inc == end_row_r);

    out_nxt = '0;
    if (!active_r) begin
      out_nxt.no_work = 1'b1;
    end else begin
      out_nxt.span_row   = cur_row_r;
      out_nxt.span_color = color_r;
      out_nxt.last_row   = done;
      if (!leave && vis) begin
        out_nxt.span_left  = left[RB-1:0];
        out_nxt.span_right = clip_r[RB-1:0];
        out_nxt.visible    = 1'b1;
      end
    end

    active_nxt = active_r;
    if (cmd.load) begin
      active_nxt = ld_ok;
    end else if (cmd.emit && active_r && done) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      screen_width_r <= tsr_pkg::SCREEN_WIDTH_RESET;
    end else begin
      active_r <= active_nxt;
      if (cfg_we) begin
        screen_width_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_row_r    <= start_row;
      end_row_r    <= stop_row;
      cur_x_r      <= ld_x1[XW-1:0];
      cur_w_r      <= ld_w1[XW-1:0];
      acc_x_r      <= '0;
      acc_w_r      <= '0;
      x_right_r    <= ld_x2 > ld_x1;
      w_shrink_r   <= ld_w1 > ld_w2;
      stop_right_r <= ld_x2 > scr;
      stop_left_r  <= (ld_x2 + ld_w2) < 0;
      color_r      <= in_data.fill_color;
    end
    if (cmd.advance && active_r) begin
      cur_x_r <= cur_x_nxt;
      cur_w_r <= cur_w_nxt;
      acc_x_r <= sum_x[FRAC_BITS-1:0];
      acc_w_r <= sum_w[FRAC_BITS-1:0];
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
      if (active_r && !leave) begin
        cur_row_r <= row_inc;
      end
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/tsr_ctrl.sv =====
module tsr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tsr_pkg::dp_sts_t sts,
  output tsr_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.is_step) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            cmd.load = 1'b1;
            if (sts.div_needed) begin
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/trapezoid_span_rasterizer_core.sv =====
// Scanline trapezoid rasterizer. Items arrive on the in_ channel: op 0 loads a
// trapezoid and returns nothing, op 1 returns the span of the next row on the
// out_ channel (or a no_work result when no trapezoid is active).
// The cfg_ channel writes the inclusive right clipping edge; it is always
// ready. It must be written only while the block is idle; the block itself
// does not enforce this. A load that is rejected or empty leaves the block
// idle. An accepted load then runs the bit-serial divider, which forms the
// x and width steps together, one quotient bit per cycle; no item is taken
// while it runs. A row item first advances the edges on the transfer, then
// clips the span and writes the output register; the result and its valid
// flag are registered, and no new item is taken before that write.
// The output register decouples the two sides: the next item is accepted while
// a result waits. When the receiver stalls, a row item holds in its clipping
// step until the output register is free.
// Reset clears the active flag, the output valid and restores the clipping edge
// to 320.
module trapezoid_span_rasterizer_core #(
  parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tsr_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tsr_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tsr_pkg::ROW_BITS-1:0] cfg_data
);

  tsr_pkg::dp_cmd_t cmd;
  tsr_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
